[design/sgrm_pkg.sv]
package sgrm_pkg;

	localparam int MaxBlock   = 4096;
	localparam int SampleBits = 24;
	localparam int GainBits   = 16;
	localparam int SumBits    = 60;
	localparam int CountBits  = 13;
	localparam int RmsBits    = 23;
	localparam int RootBits   = 30;
	localparam int DivCycles  = 60;

	// floor(x / 5) as (x * Recip5) >> Recip5Shift, exact for x below 2^26
	localparam int Recip5Shift = 29;
	localparam logic [26:0] Recip5 = 27'd107374183;

	localparam logic [1:0] RegInputGain  = 2'd0;
	localparam logic [1:0] RegOutputGain = 2'd1;
	localparam logic [1:0] RegMonoInput  = 2'd2;

	localparam logic signed [SampleBits-1:0] SMax = {1'b0, {(SampleBits-1){1'b1}}};
	localparam logic signed [SampleBits-1:0] SMin = {1'b1, {(SampleBits-1){1'b0}}};

	typedef logic signed [SampleBits-1:0] sample_t;
	typedef logic [SumBits-1:0] sum_t;
	typedef logic [RmsBits-1:0] rms_t;

	typedef struct packed {
		logic start;
		logic done;
	} lane_ctl_t;

	function automatic sample_t gain_sat(input sample_t s, input logic [GainBits-1:0] g);
		logic signed [SampleBits+GainBits:0] p;
		logic signed [SampleBits+GainBits-12:0] q;
		begin
			p = s * $signed({1'b0, g});
			q = p[SampleBits+GainBits:12];
			if (q > $signed({{(GainBits-12){1'b0}}, SMax}))
				gain_sat = SMax;
			else if (q < $signed({{(GainBits-12){1'b1}}, SMin}))
				gain_sat = SMin;
			else
				gain_sat = q[SampleBits-1:0];
		end
	endfunction

endpackage

[design/sgrm_lane.sv]
module sgrm_lane (
	input  logic clk,
	input  logic arst_n,
	input  sgrm_pkg::lane_ctl_t ctl,
	input  sgrm_pkg::sum_t sum,
	input  logic [sgrm_pkg::CountBits-1:0] count,
	input  sgrm_pkg::rms_t avg_old,
	output sgrm_pkg::rms_t avg_new
);
	import sgrm_pkg::*;

	// restoring divide (one bit per cycle) then restoring root (one digit per cycle)
	logic [1:0]             phase_q;
	logic [5:0]             cnt_q;
	logic [SumBits-1:0]     quo_q;
	logic [CountBits:0]     rem_q;
	logic [CountBits-1:0]   den_q;
	logic [RootBits+1:0]    rrem_q;
	logic [RootBits-1:0]    root_q;
	logic [SumBits-1:0]     rad_q;
	logic [CountBits:0]     trial_d;
	logic [RootBits+1:0]    trial_r;
	logic [RootBits+1:0]    rshift;
	logic [RmsBits+2:0]     numer;
	logic [RmsBits+29:0]    div5;
	rms_t                   now_c;

	assign trial_d = {rem_q[CountBits-1:0], quo_q[SumBits-1]};
	assign rshift  = {rrem_q[RootBits-1:0], rad_q[SumBits-1:SumBits-2]};
	assign trial_r = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			cnt_q   <= '0;
		end else if (ctl.start) begin
			phase_q <= 2'd1;
			cnt_q   <= '0;
			quo_q   <= sum;
			rem_q   <= '0;
			den_q   <= count;
		end else if (phase_q == 2'd1) begin
			if (trial_d >= {1'b0, den_q}) begin
				rem_q <= trial_d - {1'b0, den_q};
				quo_q <= {quo_q[SumBits-2:0], 1'b1};
			end else begin
				rem_q <= trial_d;
				quo_q <= {quo_q[SumBits-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(DivCycles-1)) begin
				phase_q <= 2'd2;
				cnt_q   <= '0;
				rrem_q  <= '0;
				root_q  <= '0;
			end
		end else if (phase_q == 2'd2) begin
			if (cnt_q == 6'd0)
				rad_q <= quo_q;
			else begin
				rad_q <= {rad_q[SumBits-3:0], 2'b00};
				if (rshift >= trial_r) begin
					rrem_q <= rshift - trial_r;
					root_q <= {root_q[RootBits-2:0], 1'b1};
				end else begin
					rrem_q <= rshift;
					root_q <= {root_q[RootBits-2:0], 1'b0};
				end
			end
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(RootBits))
				phase_q <= 2'd3;
		end else if (phase_q == 2'd3) begin
			avg_new <= div5[Recip5Shift +: RmsBits];
			phase_q <= 2'd0;
		end
	end

	assign now_c = (root_q > RootBits'(SMax)) ? rms_t'(SMax) : root_q[RmsBits-1:0];
	assign numer = {avg_old, 2'b00} + (RmsBits+3)'(now_c) + (RmsBits+3)'(2);
	assign div5  = (RmsBits+30)'(numer) * (RmsBits+30)'(Recip5);

endmodule

[design/stereo_gain_rms_meter.sv]
// channel  signals                                                      dir
// in       in_valid, in_stall, left_sample, right_sample, last_in_block  in
// out      out_valid, out_stall, out_left, out_right, mono_mix, rms_*     out
// cfg      cfg_we, cfg_index, cfg_data                                   in
// a beat without block end goes through the calc and out states before the next accept
// a block end goes through the calc, wait and out states; the wait covers the 60-step serial
// divide, 31-step root and final scale in each channel lane
// arst_n clears sums, count, averages and config registers to their reset values
// out_stall holds the result; the next beat is taken once the result is gone
module stereo_gain_rms_meter (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sgrm_pkg::sample_t left_sample,
	input  sgrm_pkg::sample_t right_sample,
	input  logic last_in_block,
	output logic out_valid,
	input  logic out_stall,
	output sgrm_pkg::sample_t out_left,
	output sgrm_pkg::sample_t out_right,
	output sgrm_pkg::sample_t mono_mix,
	output sgrm_pkg::rms_t rms_left,
	output sgrm_pkg::rms_t rms_right,
	output logic rms_updated,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import sgrm_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StCalc = 2'd1;
	localparam logic [1:0] StWait = 2'd2;
	localparam logic [1:0] StOut  = 2'd3;

	logic [1:0]  state_q;
	logic [6:0]  wait_q;
	logic [15:0] in_gain_q, out_gain_q;
	logic        mono_q;
	sample_t     gl_q, gr_q;
	logic        last_q;
	sum_t        sum_l_q, sum_r_q;
	logic [CountBits-1:0] count_q;
	rms_t        avg_l_q, avg_r_q, new_l, new_r;
	lane_ctl_t   ctl;
	logic [2*SampleBits-1:0] sq_l, sq_r;
	sum_t        nsum_l, nsum_r;
	logic [CountBits-1:0] ncount;
	logic        closes;
	logic signed [SampleBits:0] mix_sum;
	logic        accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != StIdle);
	assign sq_l   = 48'(gl_q * gl_q);
	assign sq_r   = 48'(gr_q * gr_q);
	assign nsum_l = sum_l_q + SumBits'(sq_l);
	assign nsum_r = sum_r_q + SumBits'(sq_r);
	assign ncount = count_q + 1'b1;
	assign closes = last_q || (ncount >= CountBits'(MaxBlock));
	assign mix_sum = {gl_q[SampleBits-1], gl_q} + {gr_q[SampleBits-1], gr_q};
	assign ctl.start = (state_q == StCalc) && closes;
	assign ctl.done  = (state_q == StWait) && (wait_q == 7'd95);
	assign out_valid = (state_q == StOut);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StIdle;
			in_gain_q  <= 16'd4096;
			out_gain_q <= 16'd4096;
			mono_q     <= 1'b0;
			sum_l_q    <= '0;
			sum_r_q    <= '0;
			count_q    <= '0;
			avg_l_q    <= '0;
			avg_r_q    <= '0;
			wait_q     <= '0;
			rms_updated <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegInputGain:  in_gain_q  <= cfg_data;
					RegOutputGain: out_gain_q <= cfg_data;
					RegMonoInput:  mono_q     <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				StIdle: if (accept) begin
					gl_q   <= gain_sat(left_sample, in_gain_q);
					gr_q   <= mono_q ? gain_sat(left_sample, in_gain_q)
					                 : gain_sat(right_sample, in_gain_q);
					last_q <= last_in_block;
					state_q <= StCalc;
				end
				StCalc: begin
					out_left  <= gain_sat(gl_q, out_gain_q);
					out_right <= gain_sat(gr_q, out_gain_q);
					mono_mix  <= mix_sum[SampleBits:1];
					rms_updated <= closes;
					wait_q <= '0;
					if (closes) begin
						sum_l_q <= '0;
						sum_r_q <= '0;
						count_q <= '0;
						state_q <= StWait;
					end else begin
						sum_l_q <= nsum_l;
						sum_r_q <= nsum_r;
						count_q <= ncount;
						state_q <= StOut;
					end
				end
				StWait: begin
					wait_q <= wait_q + 7'd1;
					if (ctl.done) begin
						avg_l_q <= new_l;
						avg_r_q <= new_r;
						state_q <= StOut;
					end
				end
				StOut: if (!out_stall) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	assign rms_left  = avg_l_q;
	assign rms_right = avg_r_q;

	sgrm_lane u_lane_l (.clk, .arst_n, .ctl, .sum(nsum_l), .count(ncount),
		.avg_old(avg_l_q), .avg_new(new_l));
	sgrm_lane u_lane_r (.clk, .arst_n, .ctl, .sum(nsum_r), .count(ncount),
		.avg_old(avg_r_q), .avg_new(new_r));

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != StIdle |-> !accept) else $error("accept while busy");
	a_wait_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |=> state_q == StOut) else $error("wait did not finish");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CountBits'(MaxBlock)) else $error("count overflow");
`endif

endmodule
